>>> hdl/ctp_pkg.sv
// Shared widths, configuration register codes and the divider stage payload
// for the cubic trajectory point pipeline. No dependencies.
package ctp_pkg;

  localparam int CoordW  = 32;  // signed Q16.16 coordinate
  localparam int TimeW   = 16;  // elapsed / duration in ms
  localparam int CfgIdxW = 3;
  localparam int LinW    = 18;  // |3T - 2t|
  localparam int TsqW    = 32;  // t^2
  localparam int WW      = 50;  // t^2 * |3T - 2t|
  localparam int WHalfW  = 25;
  localparam int DenW    = 48;  // T^3
  localparam int DMagW   = 33;  // |end - start|
  localparam int PpW     = DMagW + WHalfW;
  localparam int ProdW   = 83;  // |d| * |w|
  localparam int QuoW    = 40;  // quotient bits kept before clipping
  localparam int SumW    = 42;  // start +/- rounded offset

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX   = 3'd0,
    CfgStartY   = 3'd1,
    CfgStartZ   = 3'd2,
    CfgEndX     = 3'd3,
    CfgEndY     = 3'd4,
    CfgEndZ     = 3'd5,
    CfgDuration = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [DenW-1:0] rem;   // partial remainder
    logic [QuoW-1:0] low;   // dividend bits not yet shifted in
    logic [QuoW-1:0] quo;   // quotient so far
    logic            big;   // quotient exceeds the kept range
    logic            neg;   // sign of the offset
  } ctp_div_t;

endpackage

>>> hdl/ctp_div_stage.sv
// One registered restoring-division step: shift in one dividend bit, compare
// against the divisor, subtract. Depends on ctp_pkg.
module ctp_div_stage (
  input  logic                     clk_i,
  input  logic [ctp_pkg::DenW-1:0] den_i,
  input  ctp_pkg::ctp_div_t        div_i,
  output ctp_pkg::ctp_div_t        div_o
);
  import ctp_pkg::*;

  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;
  logic            ge;
  ctp_div_t        div_d, div_q;

  always_comb begin
    shifted = {div_i.rem, div_i.low[QuoW-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
    div_d       = div_i;
    div_d.rem   = ge ? diff[DenW-1:0] : shifted[DenW-1:0];
    div_d.low   = {div_i.low[QuoW-2:0], 1'b0};
    div_d.quo   = {div_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign div_o = div_q;

endmodule

>>> hdl/ctp_axis.sv
// One coordinate axis: offset product, clip detection, 40-step pipelined
// division by T^3, rounding and saturation. Depends on ctp_pkg, ctp_div_stage.
module ctp_axis (
  input  logic                       clk_i,
  input  logic [ctp_pkg::CoordW-1:0] start_i,
  input  logic [ctp_pkg::CoordW-1:0] end_i,
  input  logic [ctp_pkg::DenW-1:0]   den_i,
  input  logic                       tzero_i,
  input  logic [ctp_pkg::WW-1:0]     wmag_i,
  input  logic                       wneg_i,
  output logic [ctp_pkg::CoordW-1:0] ref_o,
  output logic                       sat_o
);
  import ctp_pkg::*;

  localparam logic signed [SumW-1:0] MaxVal = SumW'(64'sh7FFF_FFFF);
  localparam logic signed [SumW-1:0] MinVal = -SumW'(64'sh8000_0000);

  logic [DMagW-1:0] diff;
  logic [DMagW-1:0] dmag_q;
  logic             dneg_q;
  logic [PpW-1:0]   pl_q, ph_q;
  logic             neg3_q;
  logic [ProdW-1:0] prod_q;
  logic             neg4_q;
  ctp_div_t         div_s [0:QuoW];
  logic             rnd;
  logic [QuoW:0]    qr_q;
  logic             big_q, neg_q;
  logic signed [SumW-1:0] sp, qs, sum;
  logic [CoordW-1:0] ref_d, ref_q;
  logic              sat_d, sat_q;

  // Path delta follows the static configuration.
  assign diff = {end_i[CoordW-1], end_i} - {start_i[CoordW-1], start_i};

  always_ff @(posedge clk_i) begin
    dneg_q <= diff[DMagW-1];
    dmag_q <= diff[DMagW-1] ? (~diff + DMagW'(1)) : diff;
  end

  // Split the 33x50 product into two 33x25 partial products.
  always_ff @(posedge clk_i) begin
    pl_q   <= PpW'(dmag_q) * PpW'(wmag_i[WHalfW-1:0]);
    ph_q   <= PpW'(dmag_q) * PpW'(wmag_i[WW-1:WHalfW]);
    neg3_q <= dneg_q ^ wneg_i;
    prod_q <= ProdW'(pl_q) + (ProdW'(ph_q) << WHalfW);
    neg4_q <= neg3_q;
  end

  always_ff @(posedge clk_i) begin
    div_s[0].big <= {5'd0, prod_q} >= {den_i, {QuoW{1'b0}}};
    div_s[0].rem <= DenW'(prod_q[ProdW-1:QuoW]);
    div_s[0].low <= prod_q[QuoW-1:0];
    div_s[0].quo <= '0;
    div_s[0].neg <= neg4_q;
  end

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    ctp_div_stage u_stage (
      .clk_i (clk_i),
      .den_i (den_i),
      .div_i (div_s[i]),
      .div_o (div_s[i+1])
    );
  end

  // Round half away from zero on the magnitude.
  assign rnd = {div_s[QuoW].rem, 1'b0} >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    qr_q  <= {1'b0, div_s[QuoW].quo} + (QuoW+1)'(rnd);
    big_q <= div_s[QuoW].big;
    neg_q <= div_s[QuoW].neg;
  end

  always_comb begin
    sp  = {{(SumW-CoordW){start_i[CoordW-1]}}, start_i};
    qs  = {1'b0, qr_q};
    sum = neg_q ? (sp - qs) : (sp + qs);
    if (tzero_i) begin
      ref_d = start_i;
      sat_d = 1'b0;
    end else if (big_q) begin
      ref_d = neg_q ? MinVal[CoordW-1:0] : MaxVal[CoordW-1:0];
      sat_d = 1'b1;
    end else if (sum > MaxVal) begin
      ref_d = MaxVal[CoordW-1:0];
      sat_d = 1'b1;
    end else if (sum < MinVal) begin
      ref_d = MinVal[CoordW-1:0];
      sat_d = 1'b1;
    end else begin
      ref_d = sum[CoordW-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q <= ref_d;
    sat_q <= sat_d;
  end

  assign ref_o = ref_q;
  assign sat_o = sat_q;

endmodule

>>> hdl/cubic_trajectory_point.sv
// Each start transfer yields one done_o strobe with its result.
// Throughput: one point per cycle; busy stays low, so a start may come every cycle.
// Depth is set by the 40-stage division by T^3, one quotient bit per stage.
// Reset (rst_ni low, asynchronous) clears the configuration registers and all valid bits.
// Results are strobed once and cannot be stalled by the receiver.
module cubic_trajectory_point (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ctp_pkg::TimeW-1:0]      elapsed_ms_i,
  output logic                           done_o,
  output logic [ctp_pkg::CoordW-1:0]     ref_x_o,
  output logic [ctp_pkg::CoordW-1:0]     ref_y_o,
  output logic [ctp_pkg::CoordW-1:0]     ref_z_o,
  output logic                           saturated_o,
  input  logic                           cfg_we_i,
  input  logic [ctp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ctp_pkg::CoordW-1:0]     cfg_wdata_i
);
  import ctp_pkg::*;

  // Front end 2 stages, axis 3 + QuoW division + 2 finish stages.
  localparam int Lat = 2 + 3 + QuoW + 2;

  // Configuration registers.
  logic [CoordW-1:0] start_x_q, start_y_q, start_z_q;
  logic [CoordW-1:0] end_x_q, end_y_q, end_z_q;
  logic [TimeW-1:0]  dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_z_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      end_z_q   <= '0;
      dur_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgStartX:   start_x_q <= cfg_wdata_i;
        CfgStartY:   start_y_q <= cfg_wdata_i;
        CfgStartZ:   start_z_q <= cfg_wdata_i;
        CfgEndX:     end_x_q   <= cfg_wdata_i;
        CfgEndY:     end_y_q   <= cfg_wdata_i;
        CfgEndZ:     end_z_q   <= cfg_wdata_i;
        CfgDuration: dur_q     <= cfg_wdata_i[TimeW-1:0];
        default:     ;  // drop writes beyond the register list
      endcase
    end
  end

  // T^2 and T^3 follow the duration register, registered in tt_q and then den_q;
  // they settle well before a new item reaches the divider.
  logic [TsqW-1:0] tt_q;
  logic [DenW-1:0] den_q;
  logic            tzero;

  always_ff @(posedge clk_i) begin
    tt_q  <= TsqW'(dur_q) * TsqW'(dur_q);
    den_q <= DenW'(tt_q) * DenW'(dur_q);
  end

  assign tzero = dur_q == '0;

  // Stage 1: t^2 and |3T - 2t| with its sign.
  logic [LinW-1:0] a3, b2, lin;
  logic            wneg;
  logic [TsqW-1:0] tsq_q;
  logic [LinW-1:0] lin_q;
  logic            wneg1_q;
  logic [WW-1:0]   wmag_q;
  logic            wneg2_q;

  always_comb begin
    a3   = (LinW'(dur_q) << 1) + LinW'(dur_q);
    b2   = LinW'(elapsed_ms_i) << 1;
    wneg = b2 > a3;
    lin  = wneg ? (b2 - a3) : (a3 - b2);
  end

  always_ff @(posedge clk_i) begin
    tsq_q   <= TsqW'(elapsed_ms_i) * TsqW'(elapsed_ms_i);
    lin_q   <= lin;
    wneg1_q <= wneg;
    // Stage 2: w = t^2 * |3T - 2t|.
    wmag_q  <= WW'(tsq_q) * WW'(lin_q);
    wneg2_q <= wneg1_q;
  end

  // Valid bits travel alongside the payload stages.
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start && !busy};
    end
  end

  logic sat_x, sat_y, sat_z;

  ctp_axis u_axis_x (
    .clk_i   (clk_i),
    .start_i (start_x_q),
    .end_i   (end_x_q),
    .den_i   (den_q),
    .tzero_i (tzero),
    .wmag_i  (wmag_q),
    .wneg_i  (wneg2_q),
    .ref_o   (ref_x_o),
    .sat_o   (sat_x)
  );

  ctp_axis u_axis_y (
    .clk_i   (clk_i),
    .start_i (start_y_q),
    .end_i   (end_y_q),
    .den_i   (den_q),
    .tzero_i (tzero),
    .wmag_i  (wmag_q),
    .wneg_i  (wneg2_q),
    .ref_o   (ref_y_o),
    .sat_o   (sat_y)
  );

  ctp_axis u_axis_z (
    .clk_i   (clk_i),
    .start_i (start_z_q),
    .end_i   (end_z_q),
    .den_i   (den_q),
    .tzero_i (tzero),
    .wmag_i  (wmag_q),
    .wneg_i  (wneg2_q),
    .ref_o   (ref_z_o),
    .sat_o   (sat_z)
  );

  assign busy        = 1'b0;
  assign done_o      = vld_q[Lat-1];
  assign saturated_o = sat_x | sat_y | sat_z;

`ifndef SYNTH
  // Every start transfer yields a done_o strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##47 done_o)
    else $error("missing result strobe");

  // A zero duration holds the start point on the x axis and never clips.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tzero |-> !saturated_o && ref_x_o == start_x_q)
    else $error("zero duration result wrong");

  // A clipped result shows a range limit on some axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      ref_x_o == 32'h7FFF_FFFF || ref_x_o == 32'h8000_0000 ||
      ref_y_o == 32'h7FFF_FFFF || ref_y_o == 32'h8000_0000 ||
      ref_z_o == 32'h7FFF_FFFF || ref_z_o == 32'h8000_0000)
    else $error("saturation flag without clipped axis");
`endif

endmodule

>>> tb/cubic_trajectory_point_tb.sv
// Self-checking testbench for the cubic trajectory point pipeline.
// Depends on ctp_pkg and cubic_trajectory_point; a scoreboard class predicts each point.
module cubic_trajectory_point_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctp_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;  // no register here, write is dropped
  localparam int DrainCycles = 60;                  // beyond the pipeline depth
  localparam int CycleLimit  = 400000;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [31:0] CoordMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              sat;
  } point_t;

  // Predicts the cubic point for each accepted timestamp and holds the
  // points still in flight through the pipeline.
  class point_scoreboard;
    logic signed [63:0] p0 [3];
    logic signed [63:0] p1 [3];
    logic [63:0]        dur;
    point_t             pending [$];
    int                 errors;

    function new();
      for (int a = 0; a < 3; a++) begin
        p0[a] = 0;
        p1[a] = 0;
      end
      dur = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
      case (idx)
        CfgStartX:   p0[0] = 64'($signed(data));
        CfgStartY:   p0[1] = 64'($signed(data));
        CfgStartZ:   p0[2] = 64'($signed(data));
        CfgEndX:     p1[0] = 64'($signed(data));
        CfgEndY:     p1[1] = 64'($signed(data));
        CfgEndZ:     p1[2] = 64'($signed(data));
        CfgDuration: dur = 64'(data[TimeW-1:0]);
        default: ;
      endcase
    endfunction

    // start + round(d * w / T^3), halves away from zero, clipped to int32
    function logic [31:0] offset_axis(int a, logic [63:0] wmag, bit wneg,
                                      logic [63:0] den, inout bit sat);
      logic signed [63:0] d, res, q;
      logic [63:0]        dmag;
      logic [127:0]       prod, qf, rm;
      bit                 neg;
      d = p1[a] - p0[a];
      neg = (d < 0) ^ wneg;
      dmag = (d < 0) ? -d : d;
      prod = {64'd0, dmag} * {64'd0, wmag};
      qf = prod / {64'd0, den};
      rm = prod % {64'd0, den};
      q = {24'd0, qf[39:0]};
      if ((rm << 1) >= {64'd0, den}) q = q + 1;
      if (|qf[127:40]) res = neg ? 64'(CoordMin) - 1 : 64'(CoordMax) + 1;
      else res = neg ? p0[a] - q : p0[a] + q;
      if (res > 64'(CoordMax)) begin
        res = 64'(CoordMax);
        sat = 1;
      end else if (res < 64'(CoordMin)) begin
        res = 64'(CoordMin);
        sat = 1;
      end
      return res[31:0];
    endfunction

    function void note_timestamp(logic [TimeW-1:0] t_ms);
      point_t      p;
      logic [63:0] t, lin, wmag, den;
      bit          wneg, sat;
      logic [31:0] c [3];
      sat = 0;
      t = 64'(t_ms);
      if (dur == 0) begin
        p = '{x: p0[0][31:0], y: p0[1][31:0], z: p0[2][31:0], sat: 1'b0};
      end else begin
        den = dur * dur * dur;
        wneg = (2 * t) > (3 * dur);
        lin = wneg ? 2 * t - 3 * dur : 3 * dur - 2 * t;
        wmag = t * t * lin;
        for (int a = 0; a < 3; a++) c[a] = offset_axis(a, wmag, wneg, den, sat);
        p = '{x: c[0], y: c[1], z: c[2], sat: sat};
      end
      pending = {pending, p};
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h sat=%b",
                 $realtime, got.x, got.y, got.z, got.sat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: ref_x expected %h actual %h", $realtime, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: ref_y expected %h actual %h", $realtime, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: ref_z expected %h actual %h", $realtime, want.z, got.z);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t: saturated expected %b actual %b", $realtime, want.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [TimeW-1:0]  elapsed_ms_i = '0;
  logic              done_o;
  logic [CoordW-1:0] ref_x_o, ref_y_o, ref_z_o;
  logic              saturated_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgStartX;
  logic [CoordW-1:0] cfg_wdata_i = '0;

  point_scoreboard sb = new();
  int              idle_pct = 0;   // chance in percent that the sender idles a cycle
  int              cycles = 0;
  logic [63:0]     cur_dur = 0;

  cubic_trajectory_point uut (.*);

  always #2 clk_i = ~clk_i;

  // Note each accepted transfer and check each strobed point; all values
  // are sampled at the edge, before this step's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_timestamp(elapsed_ms_i);
    if (rst_ni && done_o)
      sb.check_point('{x: ref_x_o, y: ref_y_o, z: ref_z_o, sat: saturated_o});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one timestamp, hold it until taken, then idle at random.
  task automatic send_point(logic [TimeW-1:0] t);
    start <= 1'b1;
    elapsed_ms_i <= t;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      elapsed_ms_i <= 16'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start and wait until every point in flight has come out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    if (idx == CfgDuration) cur_dur = 64'(data[TimeW-1:0]);
  endtask

  task automatic set_path(logic [31:0] sx, sy, sz, ex, ey, ez, logic [15:0] dur);
    drain();
    write_reg(CfgStartX, sx);
    write_reg(CfgStartY, sy);
    write_reg(CfgStartZ, sz);
    write_reg(CfgEndX, ex);
    write_reg(CfgEndY, ey);
    write_reg(CfgEndZ, ez);
    write_reg(CfgDuration, {16'($urandom), dur});  // upper bits are ignored
    write_reg(CfgUnused, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly inside the path, some past its end, some anywhere.
  function automatic logic [TimeW-1:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(32'(cur_dur)));
    if (r < 80) return 16'(cur_dur + $urandom_range(32'(cur_dur)));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return CoordMin;
      1: return CoordMax;
      2: return 32'($signed($urandom_range(20'hfffff)) - 32'sh80000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_dur();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      3: return 16'($urandom);
      default: return 16'($urandom_range(2000, 1));
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_point(pick_time());
  endtask

  initial begin
    int short_pts [10];
    int long_pts [6];
    short_pts = '{0, 1, 5, 9, 10, 11, 15, 20, 100, 65535};
    long_pts  = '{0, 1, 32767, 32768, 65534, 65535};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero duration after reset: the start point comes back, unsaturated.
    idle_pct = 25;
    send_point(16'd0);
    send_point(16'hffff);
    set_path(32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
             32'h000a_0000, 32'h0000_0000, 32'h8000_0000, 16'd0);
    send_point(16'd123);

    // Full-scale swing over a short path: endpoints, midpoint, overshoot.
    set_path(CoordMin, CoordMax, 32'h0000_0000, CoordMax, CoordMin, 32'h0000_8000, 16'd10);
    foreach (short_pts[k])
      send_point(16'(short_pts[k]));

    // Longest duration, tiny and huge offsets.
    set_path(32'h0000_0001, CoordMax, CoordMin, 32'h0000_0000, CoordMin, CoordMax, 16'hffff);
    foreach (long_pts[k])
      send_point(16'(long_pts[k]));

    // Shortest nonzero duration: far extrapolation saturates.
    set_path(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0000_0001, 32'hffff_ffff, 32'h0001_0000, 16'd1);
    send_point(16'd0);
    send_point(16'd1);
    send_point(16'd2);
    send_point(16'hffff);

    // Random paths; idling pattern changes every third phase.
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 25 : (ph < 6) ? 68 : 0;
      set_path(pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_dur());
      random_run(90);
      if (ph == 1) drain();   // let the pipeline empty mid-phase
      random_run(90);
    end

    drain();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
